/* hdl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* hdl/art_pkg.sv */
`timescale 1ns / 1ps
// types and constants of the address range table
// no dependencies
package art_pkg;
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned TAG_W  = 16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_HIT      = 3'd1,
        ST_MISS     = 3'd2,
        ST_FULL     = 3'd3,
        ST_EVICTED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EVICT,
        BK_FINAL
    } t_bk_state;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] range_start;
        logic [LEN_W-1:0]  range_length;
        logic [TAG_W-1:0]  section_tag;
        logic [ADDR_W-1:0] lookup_addr;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [TAG_W-1:0] found_tag;
        logic             last;
    } t_result;
endpackage

/* hdl/art_stream_if.sv */
`timescale 1ns / 1ps
// valid/ready channel carrying one payload
// no dependencies
interface art_stream_if #(
    parameter int unsigned WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/address_range_table.sv */
`timescale 1ns / 1ps
// channel   dir  payload
// i_cmd     in   cmd, range_start, range_length, section_tag, lookup_addr
// o_res     out  status, found_tag, last
// a transaction is registered in the queue before the back end takes it
// find, remove, reserved: result registered at the edge where the back end takes it
// add: take, one evicted result per overlapping slot, close eviction, then the final result
// while the sink holds the result register, the sequencer stalls
// synchronous active-low reset empties the table and the command queue
// depends on art_pkg, art_stream_if, art_front, art_back
module address_range_table #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    art_stream_if.sink   i_cmd,
    art_stream_if.source o_res
);
    art_pkg::t_cmd_item q_item;
    art_pkg::t_result   res;
    logic q_valid, q_ready;

    art_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_cmd.valid), .o_ready(i_cmd.ready),
        .i_item(art_pkg::t_cmd_item'(i_cmd.data)),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    art_back #(.ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(o_res.valid), .i_ready(o_res.ready), .o_res(res)
    );

    assign o_res.data = res;
endmodule

/* hdl/art_front.sv */
`timescale 1ns / 1ps
// front: accepts commands and holds them in a two-entry queue
// depends on art_pkg
module art_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  art_pkg::t_cmd_item    i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output art_pkg::t_cmd_item    o_item
);
    art_pkg::t_cmd_item r_q [2];
    logic r_wr, r_rd;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* hdl/art_back.sv */
`timescale 1ns / 1ps
// back: slot table, parallel compare, eviction sequencer and output register
// depends on art_pkg
module art_back #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  art_pkg::t_cmd_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output art_pkg::t_result   o_res
);
    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0]                 r_valid;
    logic [art_pkg::ADDR_W-1:0]         r_start [ENTRIES];
    logic [art_pkg::LEN_W-1:0]          r_len   [ENTRIES];
    logic [art_pkg::TAG_W-1:0]          r_tag   [ENTRIES];

    art_pkg::t_bk_state r_state, n_state;
    art_pkg::t_cmd_item r_cur;
    logic [ENTRIES-1:0] r_evict, n_evict;
    logic               r_ovalid;
    art_pkg::t_result   r_res, n_res;

    logic [ENTRIES-1:0] ovl, hit;
    logic               out_free, take, emit;
    logic [IW-1:0]      ev_idx, hit_idx, free_idx;
    logic               ev_any, hit_any, free_any;
    logic [ENTRIES-1:0] valid_after;

    // 65-bit range compares
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            ovl[i] = r_valid[i]
                && ({1'b0, i_item.range_start} < ({1'b0, r_start[i]} + {33'd0, r_len[i]}))
                && ({1'b0, r_start[i]} < ({1'b0, i_item.range_start}
                    + {33'd0, i_item.range_length}));
            hit[i] = r_valid[i] && (i_item.lookup_addr >= r_start[i])
                && ({1'b0, i_item.lookup_addr} < ({1'b0, r_start[i]} + {33'd0, r_len[i]}));
        end
    end

    always_comb begin
        ev_idx = '0; ev_any = 1'b0;
        hit_idx = '0; hit_any = 1'b0;
        free_idx = '0; free_any = 1'b0;
        valid_after = r_valid & ~r_evict;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_evict[i]) begin ev_idx = IW'(i); ev_any = 1'b1; end
            if (hit[i]) begin hit_idx = IW'(i); hit_any = 1'b1; end
            if (!valid_after[i]) begin free_idx = IW'(i); free_any = 1'b1; end
        end
    end

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == art_pkg::BK_IDLE) && out_free;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_res    = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            art_pkg::BK_IDLE:  if (take && i_item.cmd == art_pkg::CMD_ADD)
                                   n_state = art_pkg::BK_EVICT;
            art_pkg::BK_EVICT: if (out_free && !ev_any) n_state = art_pkg::BK_FINAL;
            art_pkg::BK_FINAL: if (out_free) n_state = art_pkg::BK_IDLE;
            default:           n_state = art_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_res   = r_res;
        n_evict = r_evict;
        emit    = 1'b0;
        case (r_state)
            art_pkg::BK_IDLE: begin
                if (take) begin
                    n_evict = ovl;
                    if (i_item.cmd == art_pkg::CMD_REMOVE
                            || i_item.cmd == art_pkg::CMD_FIND) begin
                        emit = 1'b1;
                        n_res.last = 1'b1;
                        n_res.status = hit_any ? art_pkg::ST_HIT : art_pkg::ST_MISS;
                        n_res.found_tag = hit_any ? r_tag[hit_idx] : '0;
                    end else if (i_item.cmd == art_pkg::CMD_RSVD) begin
                        emit = 1'b1;
                        n_res = '{art_pkg::ST_MISS, '0, 1'b1};
                    end
                end
            end
            art_pkg::BK_EVICT: begin
                if (out_free && ev_any) begin
                    emit = 1'b1;
                    n_res = '{art_pkg::ST_EVICTED, r_tag[ev_idx], 1'b0};
                    n_evict[ev_idx] = 1'b0;
                end
            end
            art_pkg::BK_FINAL: begin
                if (out_free) begin
                    emit = 1'b1;
                    n_res = '{free_any ? art_pkg::ST_INSERTED : art_pkg::ST_FULL, '0, 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_evict <= n_evict;
        if (take) r_cur <= i_item;
        if (r_state == art_pkg::BK_FINAL && out_free && free_any) begin
            r_start[free_idx] <= r_cur.range_start;
            r_len[free_idx]   <= r_cur.range_length;
            r_tag[free_idx]   <= r_cur.section_tag;
        end
        if (!i_rst_n) begin
            r_state  <= art_pkg::BK_IDLE;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (r_state == art_pkg::BK_IDLE && take && hit_any
                && i_item.cmd == art_pkg::CMD_REMOVE)
                r_valid[hit_idx] <= 1'b0;
            if (r_state == art_pkg::BK_EVICT && out_free && ev_any)
                r_valid[ev_idx] <= 1'b0;
            if (r_state == art_pkg::BK_FINAL && out_free && free_any)
                r_valid[free_idx] <= 1'b1;
        end
    end
endmodule

/* hdl/art_checker.sv */
`timescale 1ns / 1ps
// port-level checks on the address range table
// depends on assert_macros.svh, art_pkg
`include "assert_macros.svh"
module art_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input art_pkg::t_result i_res_data
);
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_data))
    `ASSERT_IMPLIES(a_status_range, i_clk, i_rst_n, i_res_valid, i_res_data.status <= art_pkg::ST_EVICTED)
    `ASSERT_IMPLIES(a_evict_not_last, i_clk, i_rst_n, i_res_valid && i_res_data.status == art_pkg::ST_EVICTED, !i_res_data.last)
    `ASSERT_IMPLIES(a_final_last, i_clk, i_rst_n, i_res_valid && i_res_data.status != art_pkg::ST_EVICTED, i_res_data.last)
endmodule

bind address_range_table art_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_res_valid(o_res.valid), .i_res_ready(o_res.ready),
    .i_res_data(art_pkg::t_result'(o_res.data))
);

/* tb/sv/address_range_table_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the address range table: directed table then random commands
// depends on art_pkg, art_stream_if and address_range_table
module address_range_table_tb;
    localparam int unsigned N_SLOTS  = 16;
    localparam int unsigned CMD_W    = $bits(art_pkg::t_cmd_item);
    localparam int unsigned RES_W    = $bits(art_pkg::t_result);
    localparam int unsigned N_RANDOM = 138;
    localparam int unsigned N_DIR    = 22;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    art_stream_if #(.WIDTH(CMD_W)) cmd_ch ();
    art_stream_if #(.WIDTH(RES_W)) res_ch ();

    address_range_table #(.TABLE_ENTRIES(N_SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic                       tbl_valid [N_SLOTS];
    logic [art_pkg::ADDR_W-1:0] tbl_start [N_SLOTS];
    logic [art_pkg::LEN_W-1:0]  tbl_len   [N_SLOTS];
    logic [art_pkg::TAG_W-1:0]  tbl_tag   [N_SLOTS];

    art_pkg::t_result pending_results[$];
    int unsigned      mismatch_count = 0;
    longint unsigned  cycle_count = 0;
    bit               stim_done = 1'b0;

    // a < base + len at 65 bits
    function automatic bit below_end(logic [art_pkg::ADDR_W-1:0] a,
                                     logic [art_pkg::ADDR_W-1:0] base,
                                     logic [art_pkg::ADDR_W-1:0] len);
        logic [art_pkg::ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, len};
        return {1'b0, a} < sum;
    endfunction

    function automatic art_pkg::t_result mk_res(art_pkg::t_status st,
                                                logic [art_pkg::TAG_W-1:0] tg, logic lst);
        art_pkg::t_result r;
        r.status = st;
        r.found_tag = tg;
        r.last = lst;
        return r;
    endfunction

    task automatic add_expected(input art_pkg::t_result r);
        pending_results = {pending_results, r};
    endtask

    task automatic predict_table(input art_pkg::t_cmd_item it);
        int hit;
        int free_slot;
        hit = -1;
        free_slot = -1;
        if (it.cmd == art_pkg::CMD_ADD) begin
            for (int i = 0; i < N_SLOTS; i++) begin
                if (tbl_valid[i] && below_end(it.range_start, tbl_start[i], 64'(tbl_len[i]))
                        && below_end(tbl_start[i], it.range_start, 64'(it.range_length))) begin
                    tbl_valid[i] = 1'b0;
                    add_expected(mk_res(art_pkg::ST_EVICTED, tbl_tag[i], 1'b0));
                end
            end
            for (int i = 0; i < N_SLOTS; i++)
                if (!tbl_valid[i] && free_slot < 0) free_slot = i;
            if (free_slot < 0) begin
                add_expected(mk_res(art_pkg::ST_FULL, '0, 1'b1));
            end else begin
                tbl_valid[free_slot] = 1'b1;
                tbl_start[free_slot] = it.range_start;
                tbl_len[free_slot]   = it.range_length;
                tbl_tag[free_slot]   = it.section_tag;
                add_expected(mk_res(art_pkg::ST_INSERTED, '0, 1'b1));
            end
        end else if (it.cmd == art_pkg::CMD_REMOVE || it.cmd == art_pkg::CMD_FIND) begin
            for (int i = 0; i < N_SLOTS; i++)
                if (hit < 0 && tbl_valid[i] && it.lookup_addr >= tbl_start[i]
                        && below_end(it.lookup_addr, tbl_start[i], 64'(tbl_len[i])))
                    hit = i;
            if (hit < 0) begin
                add_expected(mk_res(art_pkg::ST_MISS, '0, 1'b1));
            end else begin
                if (it.cmd == art_pkg::CMD_REMOVE) tbl_valid[hit] = 1'b0;
                add_expected(mk_res(art_pkg::ST_HIT, tbl_tag[hit], 1'b1));
            end
        end else begin
            add_expected(mk_res(art_pkg::ST_MISS, '0, 1'b1));
        end
    endtask

    function automatic art_pkg::t_cmd_item mk_cmd(art_pkg::t_cmd c,
                                                  logic [art_pkg::ADDR_W-1:0] b,
                                                  logic [art_pkg::LEN_W-1:0] n,
                                                  logic [art_pkg::TAG_W-1:0] tg,
                                                  logic [art_pkg::ADDR_W-1:0] a);
        art_pkg::t_cmd_item it;
        it.cmd = c;
        it.range_start = b;
        it.range_length = n;
        it.section_tag = tg;
        it.lookup_addr = a;
        return it;
    endfunction

    function automatic logic [art_pkg::ADDR_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // directed rows; fixed expectations only where obvious, otherwise predictor
    art_pkg::t_cmd_item dir_item  [N_DIR];
    bit                 dir_fixed [N_DIR];
    art_pkg::t_result   dir_res   [N_DIR];

    initial begin
        dir_item[0]  = mk_cmd(art_pkg::CMD_FIND, '0, '0, '0, '0);
        dir_fixed[0] = 1'b1; dir_res[0] = mk_res(art_pkg::ST_MISS, '0, 1'b1);
        dir_item[1]  = mk_cmd(art_pkg::CMD_REMOVE, '0, '0, '0, '1);
        dir_fixed[1] = 1'b1; dir_res[1] = mk_res(art_pkg::ST_MISS, '0, 1'b1);
        dir_item[2]  = mk_cmd(art_pkg::CMD_RSVD, '1, '1, '1, '1);
        dir_fixed[2] = 1'b1; dir_res[2] = mk_res(art_pkg::ST_MISS, '0, 1'b1);
        dir_item[3]  = mk_cmd(art_pkg::CMD_ADD, '0, '1, 16'hffff, '0);
        dir_fixed[3] = 1'b1; dir_res[3] = mk_res(art_pkg::ST_INSERTED, '0, 1'b1);
        dir_item[4]  = mk_cmd(art_pkg::CMD_FIND, '0, '0, '0, 64'hfffffffe);
        dir_fixed[4] = 1'b1; dir_res[4] = mk_res(art_pkg::ST_HIT, 16'hffff, 1'b1);
        dir_item[5]  = mk_cmd(art_pkg::CMD_FIND, '0, '0, '0, 64'hffffffff);
        dir_fixed[5] = 1'b1; dir_res[5] = mk_res(art_pkg::ST_MISS, '0, 1'b1);
        // top of address space, end needs bit 64
        dir_item[6]  = mk_cmd(art_pkg::CMD_ADD, 64'hffffffff_ffffff00, '1, 16'h0001, '0);
        dir_fixed[6] = 1'b1; dir_res[6] = mk_res(art_pkg::ST_INSERTED, '0, 1'b1);
        dir_item[7]  = mk_cmd(art_pkg::CMD_FIND, '0, '0, '0, '1);
        dir_fixed[7] = 1'b1; dir_res[7] = mk_res(art_pkg::ST_HIT, 16'h0001, 1'b1);
        // zero length add stored but never hit
        dir_item[8]  = mk_cmd(art_pkg::CMD_ADD, 64'h1_0000_0000, '0, 16'h0002, '0);
        dir_fixed[8] = 1'b0;
        dir_item[9]  = mk_cmd(art_pkg::CMD_FIND, '0, '0, '0, 64'h1_0000_0000);
        dir_fixed[9] = 1'b1; dir_res[9] = mk_res(art_pkg::ST_MISS, '0, 1'b1);
        // zero length new range inside a stored one evicts it
        dir_item[10] = mk_cmd(art_pkg::CMD_ADD, 64'h10, '0, 16'h0003, '0);
        dir_fixed[10] = 1'b0;
        dir_item[11] = mk_cmd(art_pkg::CMD_ADD, 64'h2000_0000, 32'h10, 16'h0004, '0);
        dir_fixed[11] = 1'b0;
        // overlap spanning several
        dir_item[12] = mk_cmd(art_pkg::CMD_ADD, 64'h0, 32'hffff_ffff, 16'h0005, '0);
        dir_fixed[12] = 1'b0;
        dir_item[13] = mk_cmd(art_pkg::CMD_REMOVE, '0, '0, '0, 64'h100);
        dir_fixed[13] = 1'b0;
        dir_item[14] = mk_cmd(art_pkg::CMD_REMOVE, '0, '0, '0, 64'h100);
        dir_fixed[14] = 1'b1; dir_res[14] = mk_res(art_pkg::ST_MISS, '0, 1'b1);
        dir_item[15] = mk_cmd(art_pkg::CMD_REMOVE, '0, '0, '0, '1);
        dir_fixed[15] = 1'b1; dir_res[15] = mk_res(art_pkg::ST_HIT, 16'h0001, 1'b1);
        for (int i = 16; i < N_DIR; i++) begin
            dir_item[i] = mk_cmd(art_pkg::CMD_ADD, 64'(i) << 40, 32'h1000, 16'(i), '0);
            dir_fixed[i] = 1'b0;
        end
    end

    // valid stays high across back to back transactions when the random gap is zero
    task automatic send_cmd(input art_pkg::t_cmd_item it);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        predict_table(it);
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    art_pkg::t_cmd_item rand_cmd;
    int pick;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_start[i] = '0;
            tbl_len[i]   = '0;
            tbl_tag[i]   = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < N_DIR; r++) begin
            send_cmd(dir_item[r]);
            if (dir_fixed[r]) begin
                if (pending_results[$] != dir_res[r]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("row %0d: table expects %p, predictor %p", r, dir_res[r],
                                 pending_results[$]);
                end
            end
        end
        cmd_ch.valid <= 1'b0;
        wait_drained();
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            rand_cmd = mk_cmd(art_pkg::t_cmd'($urandom_range(0, 3)), rand64(), $urandom(),
                              16'($urandom()), rand64());
            // mostly a small address window so ranges collide and lookups hit
            if (pick < 85) begin
                rand_cmd.range_start = 64'($urandom_range(0, 4095)) | (rand64() & 64'hf << 60);
                rand_cmd.range_length = (pick < 10) ? $urandom() : $urandom_range(0, 512);
                rand_cmd.lookup_addr = 64'($urandom_range(0, 4600))
                                       | (rand_cmd.range_start & 64'hf << 60);
                if (pick < 45) rand_cmd.cmd = art_pkg::CMD_ADD;
                else if (pick < 65) rand_cmd.cmd = art_pkg::CMD_FIND;
                else if (pick < 82) rand_cmd.cmd = art_pkg::CMD_REMOVE;
            end
            send_cmd(rand_cmd);
        end
        cmd_ch.valid <= 1'b0;
        wait_drained();
        stim_done = 1'b1;
    end

    // result side
    art_pkg::t_result got;
    art_pkg::t_result want;
    int res_gap = 0;

    initial res_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = art_pkg::t_result'(res_ch.data);
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected result %p", got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status || got.found_tag != want.found_tag
                            || got.last != want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %p, actual %p", want, got);
                    end
                end
                res_gap = $urandom_range(0, 4);
            end
            if (res_gap > 0) begin
                res_ch.ready <= 1'b0;
                res_gap = res_gap - 1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (!stim_done && cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        if (!stim_done) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            if (mismatch_count == 0 && pending_results.size() == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
            $finish;
        end
    end
endmodule
